@@ sv/rht_pkg.sv @@
// Shared constants, codes and types of the handle table.
`default_nettype none

package rht_pkg;

  // Table geometry: handles are 8 bits wide, so at most 256 slots are usable
  localparam int SLOTS  = 256;
  localparam int USABLE = (SLOTS < 256) ? SLOTS : 256;
  localparam int IDX_W  = $clog2(USABLE);

  // Field widths
  localparam int ACT_W = 3;
  localparam int HDL_W = 8;
  localparam int OFF_W = 64;
  localparam int FLG_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(USABLE - 1);

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD_REF    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ       = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SET_OFFSET = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SET_SEQ    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SET_FLAGS  = 3'd6;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_CLOSED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_SAT    = 2'd3;

  // Shared incrementer/decrementer with limit compare
  typedef struct packed {
    logic             op_dec;
    logic [CNT_W-1:0] operand;
    logic [CNT_W-1:0] limit;
  } rht_alu_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] result;
    logic             at_limit;
    logic             res_zero;
  } rht_alu_rsp_t;

endpackage

`default_nettype wire

@@ sv/rht_if.sv @@
// Request and response channel interfaces of the handle table.
`default_nettype none

interface rht_req_if import rht_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [HDL_W-1:0]        handle;
  logic signed [OFF_W-1:0] new_offset;
  logic [FLG_W-1:0]        new_flags;

  modport source (output valid, action, handle, new_offset, new_flags, input ready);
  modport sink   (input valid, action, handle, new_offset, new_flags, output ready);
endinterface

interface rht_rsp_if import rht_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic [HDL_W-1:0]        slot;
  logic signed [OFF_W-1:0] offset_out;
  logic signed [OFF_W-1:0] seq_offset_out;
  logic [FLG_W-1:0]        flags_out;

  modport source (output valid, status, slot, offset_out, seq_offset_out, flags_out,
                  input ready);
  modport sink   (input valid, status, slot, offset_out, seq_offset_out, flags_out,
                  output ready);
endinterface

`default_nettype wire

@@ sv/rht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/rht_alu.sv @@
// Shared count/index unit: +1 or -1 with limit and zero compare.
`default_nettype none

module rht_alu import rht_pkg::*; (
  input  wire rht_alu_req_t req,
  output rht_alu_rsp_t      rsp
);

  always_comb begin
    rsp.result   = req.op_dec ? (req.operand - CNT_W'(1)) : (req.operand + CNT_W'(1));
    rsp.at_limit = (req.operand == req.limit);
    rsp.res_zero = (rsp.result == '0);
  end

endmodule

`default_nettype wire

@@ sv/refcounted_handle_table_unit.sv @@
// Reference-counted handle table: top level with sequencer and slot stores.
//
// Usage:
//   req carries one request (action, handle, new_offset, new_flags); rsp returns
//   exactly one response (status, slot, offset_out, seq_offset_out, flags_out)
//   per request, in order. Both channels use valid/ready.
// Sequencing:
//   Actions other than allocate are read and then executed: the accept cycle
//   issues the registered read of the slot stores, and the execute state then
//   loads the response register. Allocate examines slots from the free hint
//   upward, one open bit per cycle through the shared incrementer while no
//   stall holds it, at most USABLE slots. A new request is taken only when
//   the sequencer is idle, but may be taken while a response still waits.
// Reset:
//   rst clears all open bits (every count reads as zero), the free hint and
//   the response valid. Offset and flag stores are not cleared; allocate
//   writes them as a slot opens.
// Stall:
//   If rsp is held off, the request in progress makes no step (an allocate
//   scan pauses as well) and changes no state until the response register frees.
`default_nettype none

module refcounted_handle_table_unit import rht_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  rht_req_if.sink  req,
  rht_rsp_if.source rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]              state;
  logic [ACT_W-1:0]        act;
  logic [HDL_W-1:0]        hdl;
  logic [OFF_W-1:0]        val;
  logic [FLG_W-1:0]        flg;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        hint;
  logic [USABLE-1:0]       open_bits;
  logic                    out_valid;

  logic                    accept;
  logic                    step;
  logic                    hdl_ok;
  logic                    slot_open;
  logic [IDX_W-1:0]        hidx;
  logic [IDX_W-1:0]        raddr;
  logic [IDX_W-1:0]        waddr;
  logic [CNT_W-1:0]        cnt_rdata;
  logic [OFF_W-1:0]        off_rdata;
  logic [OFF_W-1:0]        seq_rdata;
  logic [FLG_W-1:0]        flg_rdata;
  rht_alu_req_t            alu_req;
  rht_alu_rsp_t            alu_rsp;

  logic                    fin;
  logic [ST_W-1:0]         st_res;
  logic [HDL_W-1:0]        slot_res;
  logic [OFF_W-1:0]        o_off;
  logic [OFF_W-1:0]        o_seq;
  logic [FLG_W-1:0]        o_fl;
  logic                    cnt_we;
  logic [CNT_W-1:0]        cnt_wdata;
  logic                    off_we;
  logic [OFF_W-1:0]        off_wdata;
  logic                    seq_we;
  logic [OFF_W-1:0]        seq_wdata;
  logic                    flg_we;
  logic                    open_set;
  logic                    open_clr;
  logic [IDX_W-1:0]        hint_next;
  logic [IDX_W-1:0]        idx_next;

  // Handshake
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && (state == S_IDLE);
  assign step      = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;

  // Addressed slot decode
  assign hidx      = hdl[IDX_W-1:0];
  assign hdl_ok    = (32'(hdl) < USABLE);
  assign slot_open = hdl_ok && open_bits[hidx];
  assign raddr     = (state == S_IDLE) ? req.handle[IDX_W-1:0] : hidx;
  assign waddr     = (state == S_SCAN) ? idx : hidx;

  // Shared unit: scan index step in allocate, count step otherwise
  always_comb begin
    if (state == S_SCAN) begin
      alu_req.op_dec  = 1'b0;
      alu_req.operand = CNT_W'(idx);
      alu_req.limit   = CNT_W'(IDX_LAST);
    end else begin
      alu_req.op_dec  = (act == ACT_RELEASE);
      alu_req.operand = cnt_rdata;
      alu_req.limit   = CNT_MAX;
    end
  end

  rht_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Slot stores
  rht_ram #(.WIDTH(CNT_W), .DEPTH(USABLE)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(waddr), .wdata(cnt_wdata),
    .raddr(raddr), .rdata(cnt_rdata)
  );

  rht_ram #(.WIDTH(OFF_W), .DEPTH(USABLE)) u_off_ram (
    .clk(clk), .we(off_we), .waddr(waddr), .wdata(off_wdata),
    .raddr(raddr), .rdata(off_rdata)
  );

  rht_ram #(.WIDTH(OFF_W), .DEPTH(USABLE)) u_seq_ram (
    .clk(clk), .we(seq_we), .waddr(waddr), .wdata(seq_wdata),
    .raddr(raddr), .rdata(seq_rdata)
  );

  rht_ram #(.WIDTH(FLG_W), .DEPTH(USABLE)) u_flg_ram (
    .clk(clk), .we(flg_we), .waddr(waddr), .wdata(flg),
    .raddr(raddr), .rdata(flg_rdata)
  );

  // Sequencer step: decides writes and the response
  always_comb begin
    fin       = 1'b0;
    st_res    = ST_OK;
    slot_res  = hdl;
    o_off     = '0;
    o_seq     = '0;
    o_fl      = '0;
    cnt_we    = 1'b0;
    cnt_wdata = alu_rsp.result;
    off_we    = 1'b0;
    off_wdata = val;
    seq_we    = 1'b0;
    seq_wdata = val;
    flg_we    = 1'b0;
    open_set  = 1'b0;
    open_clr  = 1'b0;
    hint_next = hint;
    idx_next  = accept ? hint : idx;
    case (state)
      S_SCAN: begin
        if (step) begin
          if (!open_bits[idx]) begin
            // free slot found: open it with count one and cleared offsets
            fin       = 1'b1;
            slot_res  = HDL_W'(idx);
            cnt_we    = 1'b1;
            cnt_wdata = CNT_W'(1);
            off_we    = 1'b1;
            off_wdata = '0;
            seq_we    = 1'b1;
            seq_wdata = '0;
            flg_we    = 1'b1;
            open_set  = 1'b1;
            hint_next = idx;
          end else if (alu_rsp.at_limit) begin
            fin       = 1'b1;
            st_res    = ST_FULL;
            slot_res  = '0;
            hint_next = '0;
          end else begin
            idx_next = alu_rsp.result[IDX_W-1:0];
          end
        end
      end
      S_EXEC: begin
        if (step) begin
          fin = 1'b1;
          if (!slot_open) begin
            st_res = ST_CLOSED;
          end else begin
            case (act)
              ACT_ADD_REF: begin
                if (alu_rsp.at_limit) begin
                  st_res = ST_SAT;
                end else begin
                  cnt_we = 1'b1;
                end
              end
              ACT_RELEASE: begin
                cnt_we = 1'b1;
                if (alu_rsp.res_zero) begin
                  open_clr = 1'b1;
                  if (hidx < hint) begin
                    hint_next = hidx;
                  end
                end
              end
              ACT_READ: begin
                o_off = off_rdata;
                o_seq = seq_rdata;
                o_fl  = flg_rdata;
              end
              ACT_SET_OFFSET: off_we = 1'b1;
              ACT_SET_SEQ:    seq_we = 1'b1;
              ACT_SET_FLAGS:  flg_we = 1'b1;
              default:        st_res = ST_CLOSED;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      hint      <= '0;
      open_bits <= '0;
    end else begin
      if (accept) begin
        state <= (req.action == ACT_ALLOC) ? S_SCAN : S_EXEC;
      end else if (fin) begin
        state <= S_IDLE;
      end
      if (fin) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      hint <= hint_next;
      if (open_set) begin
        open_bits[idx] <= 1'b1;
      end
      if (open_clr) begin
        open_bits[hidx] <= 1'b0;
      end
    end
  end

  // Request latch, scan index and response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act <= req.action;
      hdl <= req.handle;
      val <= req.new_offset;
      flg <= req.new_flags;
    end
    idx <= idx_next;
    if (fin) begin
      rsp.status         <= st_res;
      rsp.slot           <= slot_res;
      rsp.offset_out     <= o_off;
      rsp.seq_offset_out <= o_seq;
      rsp.flags_out      <= o_fl;
    end
  end

endmodule

`default_nettype wire

@@ sv/rht_checker.sv @@
// Port-level checks of the handle table, bound to the top level.
`default_nettype none

module rht_checker import rht_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    req_valid,
  input wire logic                    req_ready,
  input wire logic                    rsp_valid,
  input wire logic                    rsp_ready,
  input wire logic [ST_W-1:0]         rsp_status,
  input wire logic [HDL_W-1:0]        rsp_slot,
  input wire logic signed [OFF_W-1:0] rsp_offset_out,
  input wire logic signed [OFF_W-1:0] rsp_seq_offset_out,
  input wire logic [FLG_W-1:0]        rsp_flags_out
);

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
      && $stable(rsp_offset_out) && $stable(rsp_seq_offset_out) && $stable(rsp_flags_out))
    else $error("response changed while stalled");

  // One request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // Full table reports slot zero
  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL) |-> (rsp_slot == '0))
    else $error("full status with nonzero slot");

  // Only a successful request may carry payload data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_OK) |->
      (rsp_offset_out == '0) && (rsp_seq_offset_out == '0) && (rsp_flags_out == '0))
    else $error("failed request returned data");

  // No response right out of reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind refcounted_handle_table_unit rht_checker u_rht_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_slot           (rsp.slot),
  .rsp_offset_out     (rsp.offset_out),
  .rsp_seq_offset_out (rsp.seq_offset_out),
  .rsp_flags_out      (rsp.flags_out)
);

`default_nettype wire
